// ----- rtl/qsvge_pkg.sv -----
// shared types and constants for the state-vector gate engine
package qsvge_pkg;
	typedef enum logic [2:0] {
		ACT_INIT = 3'd0,
		ACT_X    = 3'd1,
		ACT_Z    = 3'd2,
		ACT_H    = 3'd3,
		ACT_MCX  = 3'd4,
		ACT_MCZ  = 3'd5,
		ACT_MEAS = 3'd6,
		ACT_NONE = 3'd7
	} action_t;

	localparam logic [16:0] INV_SQRT2_Q16 = 17'd46341;
	localparam int QUBITS_RESET = 10;

	// pass the datapath runs for one walk over the vector
	typedef enum logic [2:0] {
		PASS_CLEAR,
		PASS_X,
		PASS_NEG,
		PASS_H,
		PASS_SWAP,
		PASS_SUM,
		PASS_SCALE
	} pass_t;

	typedef struct packed {
		logic  start;
		pass_t pass;
		logic  sum_sel;
		logic  root_start;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic root_done;
	} stat_t;
endpackage

// ----- rtl/qsvge_if.sv -----
// valid/ready channel interfaces
interface qsvge_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [3:0]  target_qubit;
	logic [9:0]  qubit_mask;
	logic [15:0] random_value;
	modport source (output valid, action, target_qubit, qubit_mask, random_value, input ready);
	modport sink (input valid, action, target_qubit, qubit_mask, random_value, output ready);
endinterface

interface qsvge_out_if;
	logic        valid;
	logic        ready;
	logic        measured_bit;
	logic [15:0] prob_one;
	modport source (output valid, measured_bit, prob_one, input ready);
	modport sink (input valid, measured_bit, prob_one, output ready);
endinterface

interface qsvge_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- rtl/qsvge_isqrt.sv -----
// iterative integer square root, one result bit per cycle
module qsvge_isqrt #(
	parameter int W = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [W-1:0]     value,
	output logic             done,
	output logic [W/2-1:0]   root
);
	localparam int CW = $clog2(W/2 + 1);
	logic [W/2-1:0] res_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic [W/2+1:0] trial;

	assign trial  = {res_q, 2'b01};
	assign root   = res_q;

	// restoring method: bring down two bits, try subtracting 4r+1
	logic [W-1:0]   src_q;
	logic [W/2+1:0] acc_q;
	logic [W/2+1:0] acc_n;
	logic [W/2+1:0] diff;
	always_comb begin
		acc_n = {acc_q[W/2-1:0], src_q[W-1:W-2]};
		diff  = acc_n - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
			res_q  <= '0;
			acc_q  <= '0;
			src_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W/2);
				res_q  <= '0;
				acc_q  <= '0;
				src_q  <= value;
			end else if (busy_q) begin
				src_q <= {src_q[W-3:0], 2'b00};
				if (!diff[W/2+1]) begin
					acc_q <= diff;
					res_q <= {res_q[W/2-2:0], 1'b1};
				end else begin
					acc_q <= acc_n;
					res_q <= {res_q[W/2-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule

// ----- rtl/qsvge_datapath.sv -----
// amplitude memory, pass walker and arithmetic
module qsvge_datapath #(
	parameter int MAX_QUBITS = 10,
	parameter int AMP_BITS   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  qsvge_pkg::cmd_t       cmd,
	output qsvge_pkg::stat_t      stat,
	input  logic [MAX_QUBITS-1:0] len_mask,
	input  logic [MAX_QUBITS-1:0] tb,
	input  logic [MAX_QUBITS-1:0] opmask,
	input  logic                  want,
	output logic [63:0]           sum
);
	import qsvge_pkg::*;
	localparam int D    = 1 << MAX_QUBITS;
	localparam int FRAC = AMP_BITS - 2;
	localparam int A    = MAX_QUBITS;
	localparam int SW   = 64;

	typedef logic signed [AMP_BITS-1:0] part_t;

	logic [2*AMP_BITS-1:0] mem [D];
	logic [A:0]            idx_q;
	logic                  busy_q;
	pass_t                 pass_q;
	logic [1:0]            ph_q;
	logic [A-1:0]          ia_q, ib_q;
	logic [2*AMP_BITS-1:0] ra_q, rb_q;
	logic [SW-1:0]         sum_q;
	logic                  sel_q;
	logic [31:0]           root_q;

	function automatic part_t sat(input logic signed [AMP_BITS+18:0] v);
		logic signed [AMP_BITS+18:0] hi;
		hi = (AMP_BITS+19)'((1 << (AMP_BITS-1)) - 1);
		if (v > hi) return part_t'(hi);
		if (v < -hi - 1) return part_t'(-hi - 1);
		return part_t'(v);
	endfunction

	function automatic part_t hbf(input part_t a, input part_t b, input logic sub);
		logic signed [AMP_BITS:0]    s;
		logic signed [AMP_BITS+18:0] p, r;
		logic [AMP_BITS+18:0]        m;
		s = sub ? ($signed({a[AMP_BITS-1], a}) - b) : ($signed({a[AMP_BITS-1], a}) + b);
		p = s * $signed({2'b00, INV_SQRT2_Q16});
		if (p >= 0) r = (p + 32768) >>> 16;
		else begin
			m = -p;
			r = -$signed((m + 32767) >> 16);
		end
		return sat(r);
	endfunction

	function automatic logic [SW-1:0] sq(input logic [2*AMP_BITS-1:0] w);
		logic signed [AMP_BITS-1:0] re, im;
		logic [2*AMP_BITS:0]        s;
		re = w[2*AMP_BITS-1:AMP_BITS];
		im = w[AMP_BITS-1:0];
		s  = (2*AMP_BITS+1)'(re * re) + (2*AMP_BITS+1)'(im * im);
		if (2*FRAC >= 32) return SW'(s >> (2*FRAC - 32));
		return SW'(s) << (32 - 2*FRAC);
	endfunction

	function automatic logic [2*AMP_BITS-1:0] neg(input logic [2*AMP_BITS-1:0] w);
		part_t re, im;
		re = w[2*AMP_BITS-1:AMP_BITS];
		im = w[AMP_BITS-1:0];
		return {sat(-(AMP_BITS+19)'(re)), sat(-(AMP_BITS+19)'(im))};
	endfunction

	// rescale by shift-subtract division, one quotient bit a cycle
	logic [AMP_BITS+15:0] dnum_q;
	logic [AMP_BITS+16:0] drem_q;
	logic [AMP_BITS+15:0] dquo_q;
	logic [5:0]           dcnt_q;
	logic                 dre_q;
	logic [AMP_BITS+16:0] dtry;
	assign dtry = {drem_q[AMP_BITS+15:0], dnum_q[AMP_BITS+15]} - (AMP_BITS+17)'(root_q);

	function automatic logic [AMP_BITS+15:0] magp(input part_t v);
		return (AMP_BITS+16)'(v < 0 ? -(AMP_BITS+1)'(v) : (AMP_BITS+1)'(v)) << 16;
	endfunction

	function automatic part_t sgnq(input logic [AMP_BITS+15:0] q, input logic n);
		logic signed [AMP_BITS+18:0] v;
		v = q > (AMP_BITS+16)'(1 << AMP_BITS) ? (AMP_BITS+19)'(1 << AMP_BITS)
			: (AMP_BITS+19)'(q);
		return sat(n ? -v : v);
	endfunction

	logic         root_done;
	logic [31:0]  root;
	qsvge_isqrt #(.W(SW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(cmd.root_start), .value(sum_q),
		.done(root_done), .root(root)
	);

	logic         last;
	logic [A-1:0] i;
	assign i    = idx_q[A-1:0];
	assign last = ((i & len_mask) == len_mask) || ((i & ~len_mask) != '0);
	part_t res_re_q;

	always_ff @(posedge clk) begin
		if (busy_q) begin
			unique case (pass_q)
				PASS_CLEAR: mem[i] <= (i == opmask) ? {part_t'(1 << FRAC), part_t'(0)} : '0;
				default: begin
					unique case (ph_q)
						2'd0: begin ra_q <= mem[i]; end
						2'd1: begin rb_q <= mem[ib_q]; end
						2'd2: begin
							unique case (pass_q)
								PASS_X, PASS_SWAP: mem[ia_q] <= rb_q;
								PASS_NEG: mem[ia_q] <= neg(ra_q);
								PASS_H: mem[ia_q] <= {
									hbf(ra_q[2*AMP_BITS-1:AMP_BITS], rb_q[2*AMP_BITS-1:AMP_BITS], 1'b0),
									hbf(ra_q[AMP_BITS-1:0], rb_q[AMP_BITS-1:0], 1'b0)};
								PASS_SCALE: if (dcnt_q == 6'd0 && !dre_q)
									mem[ia_q] <= ((ia_q & tb) != (want ? tb : '0)) ? '0 :
										(root_q == '0) ? ra_q :
										{res_re_q, sgnq(dquo_q, ra_q[AMP_BITS-1])};
								default: ;
							endcase
						end
						default: begin
							unique case (pass_q)
								PASS_X, PASS_SWAP: mem[ib_q] <= ra_q;
								PASS_H: mem[ib_q] <= {
									hbf(ra_q[2*AMP_BITS-1:AMP_BITS], rb_q[2*AMP_BITS-1:AMP_BITS], 1'b1),
									hbf(ra_q[AMP_BITS-1:0], rb_q[AMP_BITS-1:0], 1'b1)};
								default: ;
							endcase
						end
					endcase
				end
			endcase
		end
	end

	// which entries a pass touches, and the partner of each
	logic act;
	always_comb begin
		act = 1'b0;
		unique case (pass_q)
			PASS_X:     act = (i ^ opmask) > i;
			PASS_NEG:   act = ((i & tb) != '0) && ((i & opmask) == opmask);
			PASS_H:     act = (i & tb) == '0;
			PASS_SWAP:  act = ((i & tb) == '0) && ((i & opmask) == opmask);
			PASS_SUM:   act = sel_q ? ((i & tb) == (want ? tb : '0)) : ((i & tb) != '0);
			PASS_SCALE: act = 1'b1;
			default:    act = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0; idx_q <= '0; ph_q <= '0; pass_q <= PASS_CLEAR;
			sum_q <= '0; sel_q <= 1'b0; stat <= '0; root_q <= '0;
			dcnt_q <= '0; dre_q <= 1'b0; ia_q <= '0; ib_q <= '0;
			dnum_q <= '0; drem_q <= '0; dquo_q <= '0; res_re_q <= '0;
		end else begin
			stat.done <= 1'b0;
			stat.root_done <= root_done;
			if (root_done) root_q <= root;
			if (cmd.start) begin
				busy_q <= 1'b1; pass_q <= cmd.pass; idx_q <= '0; ph_q <= '0;
				sel_q <= cmd.sum_sel; sum_q <= '0;
			end else if (busy_q) begin
				if (pass_q == PASS_CLEAR) begin
					idx_q <= idx_q + 1'b1;
					if (idx_q[A-1:0] == A'(D-1)) begin busy_q <= 1'b0; stat.done <= 1'b1; end
				end else if (ph_q == 2'd0 && !act) begin
					idx_q <= idx_q + 1'b1;
					if (last) begin busy_q <= 1'b0; stat.done <= 1'b1; end
				end else begin
					if (ph_q == 2'd0) begin
						ia_q <= i;
						unique case (pass_q)
							PASS_X:  ib_q <= i ^ opmask;
							default: ib_q <= i | tb;
						endcase
						ph_q <= 2'd1;
					end else if (ph_q == 2'd1) begin
						if (pass_q == PASS_SUM) begin
							sum_q <= sum_q + sq(ra_q);
							ph_q  <= 2'd0; idx_q <= idx_q + 1'b1;
							if (last) begin busy_q <= 1'b0; stat.done <= 1'b1; end
						end else if (pass_q == PASS_SCALE) begin
							ph_q <= 2'd2; dre_q <= 1'b1; dcnt_q <= 6'(AMP_BITS+16);
							dnum_q <= magp(ra_q[2*AMP_BITS-1:AMP_BITS]); drem_q <= '0; dquo_q <= '0;
						end else ph_q <= 2'd2;
					end else if (ph_q == 2'd2) begin
						if (pass_q == PASS_SCALE) begin
							if (dcnt_q != 6'd0) begin
								dnum_q <= dnum_q << 1;
								dcnt_q <= dcnt_q - 1'b1;
								if (!dtry[AMP_BITS+16]) begin
									drem_q <= dtry; dquo_q <= {dquo_q[AMP_BITS+14:0], 1'b1};
								end else begin
									drem_q <= {drem_q[AMP_BITS+15:0], dnum_q[AMP_BITS+15]};
									dquo_q <= {dquo_q[AMP_BITS+14:0], 1'b0};
								end
							end else if (dre_q) begin
								res_re_q <= sgnq(dquo_q, ra_q[2*AMP_BITS-1]);
								dre_q <= 1'b0; dcnt_q <= 6'(AMP_BITS+16);
								dnum_q <= magp(ra_q[AMP_BITS-1:0]); drem_q <= '0; dquo_q <= '0;
							end else begin
								ph_q <= 2'd0; idx_q <= idx_q + 1'b1;
								if (last) begin busy_q <= 1'b0; stat.done <= 1'b1; end
							end
						end else if (pass_q == PASS_NEG) begin
							ph_q <= 2'd0; idx_q <= idx_q + 1'b1;
							if (last) begin busy_q <= 1'b0; stat.done <= 1'b1; end
						end else ph_q <= 2'd3;
					end else begin
						ph_q <= 2'd0; idx_q <= idx_q + 1'b1;
						if (last) begin busy_q <= 1'b0; stat.done <= 1'b1; end
					end
				end
			end
		end
	end

	assign sum = sum_q;
endmodule

// ----- rtl/qsvge_ctrl.sv -----
// operation sequencer
module qsvge_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic [2:0]            action,
	input  logic                  tok,
	input  logic [63:0]           sum,
	input  logic [15:0]           rnd,
	input  qsvge_pkg::stat_t      stat,
	output qsvge_pkg::cmd_t       cmd,
	output logic                  busy,
	output logic                  fin,
	output logic                  want,
	output logic [15:0]           prob
);
	import qsvge_pkg::*;
	typedef enum logic [2:0] {S_IDLE, S_RUN, S_P1, S_NK, S_ROOT, S_SCALE} state_t;
	state_t state_q;
	assign busy = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; cmd <= '0; fin <= 1'b0; want <= 1'b0; prob <= '0;
		end else begin
			cmd.start <= 1'b0; cmd.root_start <= 1'b0; fin <= 1'b0;
			unique case (state_q)
				S_IDLE: if (go) begin
					want <= 1'b0; prob <= '0;
					unique case (action_t'(action)) inside
						ACT_INIT: begin cmd.start <= 1'b1; cmd.pass <= PASS_CLEAR; state_q <= S_RUN; end
						ACT_X: begin cmd.start <= 1'b1; cmd.pass <= PASS_X; state_q <= S_RUN; end
						ACT_Z, ACT_MCZ: if (tok) begin
							cmd.start <= 1'b1; cmd.pass <= PASS_NEG; state_q <= S_RUN;
						end else fin <= 1'b1;
						ACT_H: if (tok) begin
							cmd.start <= 1'b1; cmd.pass <= PASS_H; state_q <= S_RUN;
						end else fin <= 1'b1;
						ACT_MCX: if (tok) begin
							cmd.start <= 1'b1; cmd.pass <= PASS_SWAP; state_q <= S_RUN;
						end else fin <= 1'b1;
						ACT_MEAS: if (tok) begin
							cmd.start <= 1'b1; cmd.pass <= PASS_SUM; cmd.sum_sel <= 1'b0;
							state_q <= S_P1;
						end else fin <= 1'b1;
						default: fin <= 1'b1;
					endcase
				end
				S_RUN: if (stat.done) begin state_q <= S_IDLE; fin <= 1'b1; end
				S_P1: if (stat.done) begin
					want <= {rnd, 16'h0000} < sum;
					prob <= (sum[63:32] != '0) ? 16'hFFFF : sum[31:16];
					cmd.start <= 1'b1; cmd.pass <= PASS_SUM; cmd.sum_sel <= 1'b1;
					state_q <= S_NK;
				end
				S_NK: if (stat.done) begin cmd.root_start <= 1'b1; state_q <= S_ROOT; end
				S_ROOT: if (stat.root_done) begin
					cmd.start <= 1'b1; cmd.pass <= PASS_SCALE; state_q <= S_SCALE;
				end
				S_SCALE: if (stat.done) begin state_q <= S_IDLE; fin <= 1'b1; end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/quantum_state_vector_gate_engine.sv -----
// top level of the state-vector gate engine
// Holds 2^n complex Q1.14 amplitudes in one single-port memory and applies one
// operation per input transaction, returning one result transaction each.
// Every gate walks the active 2^n entries: an untouched entry is only read,
// a negated one is read and written back, a swapped or butterflied pair takes
// two reads and two writes on the one memory port; init sweeps all 2^MAX_QUBITS
// entries, one a cycle, which also serves as the post-reset load of the basis
// state. Measure makes two summing passes, a square root, and a rescale pass
// with two bit-serial divisions per entry. While the reset sweep runs no item
// is taken; configuration writes always are.
module quantum_state_vector_gate_engine #(
	parameter int MAX_QUBITS = 10,
	parameter int AMP_BITS   = 16
) (
	input logic        clk,
	input logic        arst_n,
	qsvge_in_if.sink   in_ch,
	qsvge_out_if.source out_ch,
	qsvge_cfg_if.sink  cfg
);
	import qsvge_pkg::*;

	logic [3:0]            qubits_q;
	logic [3:0]            n_eff;
	logic [MAX_QUBITS-1:0] len_mask, tb, mask_q, opmask;
	logic [3:0]            tgt_q;
	logic [2:0]            act_q;
	logic [15:0]           rnd_q;
	logic                  tok;
	logic                  go_q, rst_sweep_q, out_v_q;
	cmd_t                  cmd, cmd_dp;
	stat_t                 stat;
	logic [63:0]           sum;
	logic                  busy, fin, want;
	logic [15:0]           prob;

	// effective qubit count, clamped to one .. MAX_QUBITS
	always_comb begin
		n_eff = qubits_q;
		if (n_eff == 4'd0) n_eff = 4'd1;
		if (32'(n_eff) > MAX_QUBITS) n_eff = 4'(MAX_QUBITS);
	end
	assign len_mask = MAX_QUBITS'((32'd1 << n_eff) - 1);
	assign tok      = tgt_q < n_eff;
	assign tb       = tok ? MAX_QUBITS'(32'd1 << tgt_q) : '0;
	// x flips the mask and init loads it; z has no controls; controlled gates use the
	// controls minus the target
	assign opmask   = (act_q == ACT_X || act_q == ACT_INIT) ? (mask_q & len_mask)
		: (act_q == ACT_Z) ? '0
		: (mask_q & len_mask & ~tb);

	assign cfg.ready   = 1'b1;
	// the finishing cycle also blocks, since the result register loads then
	assign in_ch.ready = !busy && !go_q && !out_v_q && !rst_sweep_q && !fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qubits_q <= 4'(QUBITS_RESET > MAX_QUBITS ? MAX_QUBITS : QUBITS_RESET);
			go_q <= 1'b1; rst_sweep_q <= 1'b1; out_v_q <= 1'b0;
			act_q <= ACT_INIT; mask_q <= '0; tgt_q <= '0; rnd_q <= '0;
			out_ch.measured_bit <= 1'b0; out_ch.prob_one <= '0;
		end else begin
			if (cfg.valid) qubits_q <= cfg.data;
			go_q <= 1'b0;
			if (in_ch.valid && in_ch.ready) begin
				act_q <= in_ch.action; tgt_q <= in_ch.target_qubit;
				mask_q <= MAX_QUBITS'(in_ch.qubit_mask); rnd_q <= in_ch.random_value;
				go_q <= 1'b1;
			end
			if (fin) begin
				if (rst_sweep_q) rst_sweep_q <= 1'b0;
				else begin
					out_v_q <= 1'b1;
					out_ch.measured_bit <= act_q == ACT_MEAS && tok && want;
					out_ch.prob_one <= (act_q == ACT_MEAS && tok) ? prob : '0;
				end
			end
			if (out_v_q && out_ch.ready) out_v_q <= 1'b0;
		end
	end
	assign out_ch.valid = out_v_q;
	assign cmd_dp = cmd;

	qsvge_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .go(go_q), .action(act_q), .tok(tok),
		.sum(sum), .rnd(rnd_q), .stat(stat), .cmd(cmd),
		.busy(busy), .fin(fin), .want(want), .prob(prob)
	);

	qsvge_datapath #(.MAX_QUBITS(MAX_QUBITS), .AMP_BITS(AMP_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_dp), .stat(stat), .len_mask(len_mask),
		.tb(tb), .opmask(opmask), .want(want), .sum(sum)
	);

	// no new item while one is at work
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ch.ready) else $error("accepted while busy");
	// a result appears only after an operation finishes
	a_out_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(fin)) else $error("result without finish");
endmodule

// ----- verif/qsvge_tb_if.sv -----
// note: channel interfaces are defined with the rtl in qsvge_if.sv
// this file holds the transaction types shared by the testbench
package qsvge_tb_pkg;
	import qsvge_pkg::*;

	typedef struct {
		action_t     act;
		logic [3:0]  target;
		logic [9:0]  mask;
		logic [15:0] draw;
	} gate_op_t;

	typedef struct {
		logic        outcome;
		logic [15:0] prob;
	} meas_res_t;
endpackage

// ----- verif/testbench.sv -----
// self-checking testbench for the state-vector gate engine
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import qsvge_pkg::*;
	import qsvge_tb_pkg::*;

	localparam int DEPTH      = 1024;
	localparam int ONE_AMP    = 1 << 14;
	localparam int IDLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qsvge_in_if  in_ch();
	qsvge_out_if out_ch();
	qsvge_cfg_if cfg();

	quantum_state_vector_gate_engine uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	always #4 clk = ~clk;

	// predictor state: amplitude register and active qubit count
	int amp_re [DEPTH];
	int amp_im [DEPTH];
	logic [3:0] qubit_cfg = 4'd10;

	gate_op_t  pending_ops [$];
	meas_res_t expected_results [$];
	int  mismatches = 0;
	int  idle_cycles = 0;
	int  in_gap = 0;
	int  out_stall = 0;
	bit  op_taken = 0;
	bit  calm = 0;

	function automatic int sat_amp(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return int'(v);
	endfunction

	function automatic longint unsigned magnitude(int v);
		return (v < 0) ? longint'(-longint'(v)) : longint'(v);
	endfunction

	function automatic longint round_q16(longint p);
		if (p >= 0) return (p + 32768) >>> 16;
		return -((-p + 32767) >>> 16);
	endfunction

	// |a|^2 moved from 28 to 32 fraction bits
	function automatic longint unsigned power_of(int idx);
		longint unsigned r, m;
		r = magnitude(amp_re[idx]);
		m = magnitude(amp_im[idx]);
		return (r * r + m * m) << 4;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic int renorm(int a, longint unsigned s);
		longint unsigned q;
		q = (magnitude(a) << 16) / s;
		return sat_amp(a < 0 ? -longint'(q) : longint'(q));
	endfunction

	function automatic int active_qubits();
		if (qubit_cfg < 1) return 1;
		if (qubit_cfg > 10) return 10;
		return qubit_cfg;
	endfunction

	// append one operation to the pending queue
	function automatic void enqueue_op(gate_op_t op);
		pending_ops.insert(pending_ops.size(), op);
	endfunction

	// applies one operation to the register and returns the measurement result
	function automatic meas_res_t apply_gate(gate_op_t op);
		meas_res_t r;
		int n, len, mask, tb, ctl, want, lo, hi, ar, ai, br, bi;
		bit tok, one;
		int old_re [DEPTH];
		int old_im [DEPTH];
		longint unsigned p1, nk, s;
		n = active_qubits();
		len = 1 << n;
		mask = int'(op.mask) & (len - 1);
		tok = op.target < n;
		tb = tok ? (1 << op.target) : 0;
		ctl = mask & ~tb;
		r.outcome = 1'b0;
		r.prob = '0;
		case (op.act)
			ACT_INIT: begin
				for (int i = 0; i < DEPTH; i++) begin
					amp_re[i] = 0;
					amp_im[i] = 0;
				end
				amp_re[mask] = ONE_AMP;
			end
			ACT_X: begin
				old_re = amp_re;
				old_im = amp_im;
				for (int i = 0; i < len; i++) begin
					amp_re[i ^ mask] = old_re[i];
					amp_im[i ^ mask] = old_im[i];
				end
			end
			ACT_Z, ACT_MCZ: begin
				if (tok)
					for (int i = 0; i < len; i++)
						if ((i & tb) && (op.act == ACT_Z || (i & ctl) == ctl)) begin
							amp_re[i] = sat_amp(-longint'(amp_re[i]));
							amp_im[i] = sat_amp(-longint'(amp_im[i]));
						end
			end
			ACT_H: begin
				if (tok)
					for (int i = 0; i < len; i++)
						if (!(i & tb)) begin
							ar = amp_re[i]; ai = amp_im[i];
							br = amp_re[i | tb]; bi = amp_im[i | tb];
							amp_re[i] = sat_amp(round_q16((longint'(ar) + br) * 46341));
							amp_im[i] = sat_amp(round_q16((longint'(ai) + bi) * 46341));
							amp_re[i | tb] = sat_amp(round_q16((longint'(ar) - br) * 46341));
							amp_im[i | tb] = sat_amp(round_q16((longint'(ai) - bi) * 46341));
						end
			end
			ACT_MCX: begin
				if (tok)
					for (int i = 0; i < len; i++)
						if (!(i & tb) && (i & ctl) == ctl) begin
							lo = i;
							hi = i | tb;
							ar = amp_re[lo]; ai = amp_im[lo];
							amp_re[lo] = amp_re[hi]; amp_im[lo] = amp_im[hi];
							amp_re[hi] = ar; amp_im[hi] = ai;
						end
			end
			ACT_MEAS: begin
				if (tok) begin
					p1 = 0;
					nk = 0;
					for (int i = 0; i < len; i++)
						if (i & tb) p1 += power_of(i);
					one = (longint'(op.draw) << 16) < p1;
					want = one ? tb : 0;
					for (int i = 0; i < len; i++)
						if ((i & tb) == want) nk += power_of(i);
					s = int_sqrt(nk);
					for (int i = 0; i < len; i++) begin
						if ((i & tb) != want) begin
							amp_re[i] = 0;
							amp_im[i] = 0;
						end else if (s != 0) begin
							amp_re[i] = renorm(amp_re[i], s);
							amp_im[i] = renorm(amp_im[i], s);
						end
					end
					r.outcome = one;
					r.prob = ((p1 >> 16) > 65535) ? 16'hFFFF : 16'((p1 >> 16));
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// mostly short gaps, a few long ones, none in calm stretches
	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (calm || k < 65) return 0;
		if (k < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic gate_op_t make_op(action_t a, int t, int m, int d);
		gate_op_t op;
		op.act = a;
		op.target = 4'(t);
		op.mask = 10'(m);
		op.draw = 16'(d);
		return op;
	endfunction

	// weighted toward superpositions followed by measurement
	function automatic gate_op_t random_op(int n, bit allow_meas);
		gate_op_t op;
		int k;
		k = $urandom_range(0, 99);
		if (!allow_meas && k >= 76 && k < 96) k = 40;
		if (k < 10) op.act = ACT_INIT;
		else if (k < 22) op.act = ACT_X;
		else if (k < 34) op.act = ACT_Z;
		else if (k < 58) op.act = ACT_H;
		else if (k < 68) op.act = ACT_MCX;
		else if (k < 76) op.act = ACT_MCZ;
		else if (k < 96) op.act = ACT_MEAS;
		else op.act = ACT_NONE;
		op.target = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, n - 1))
			: 4'($urandom_range(0, 15));
		op.mask = 10'($urandom);
		op.draw = 16'($urandom);
		return op;
	endfunction

	// input driver: launch next pending operation on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || op_taken) begin
			op_taken = 0;
			if (in_gap > 0) begin
				in_gap--;
				in_ch.valid <= 1'b0;
			end else if (pending_ops.size() > 0) begin
				in_ch.valid        <= 1'b1;
				in_ch.action       <= pending_ops[0].act;
				in_ch.target_qubit <= pending_ops[0].target;
				in_ch.qubit_mask   <= pending_ops[0].mask;
				in_ch.random_value <= pending_ops[0].draw;
				in_gap = pick_gap();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (out_stall > 0) begin
			out_stall--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
			out_stall = pick_gap();
		end
	end

	// monitor: predict on every accepted operation, check every result
	always @(posedge clk) begin
		meas_res_t exp_r;
		idle_cycles++;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			expected_results.insert(expected_results.size(), apply_gate(pending_ops[0]));
			void'(pending_ops.pop_front());
			op_taken = 1;
			idle_cycles = 0;
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			idle_cycles = 0;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction bit=%0d prob=%0d",
						out_ch.measured_bit, out_ch.prob_one);
			end else begin
				exp_r = expected_results.pop_front();
				if (out_ch.measured_bit !== exp_r.outcome || out_ch.prob_one !== exp_r.prob) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected bit=%0d prob=%0d got bit=%0d prob=%0d",
							exp_r.outcome, exp_r.prob, out_ch.measured_bit, out_ch.prob_one);
				end
			end
		end
		if (cfg.valid && cfg.ready) idle_cycles = 0;
		if (pending_ops.size() == 0 && expected_results.size() == 0) idle_cycles = 0;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_qubits(int v);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.data  <= 4'(v);
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		qubit_cfg = 4'(v);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic drain();
		@(posedge clk);
		while (pending_ops.size() > 0 || expected_results.size() > 0) @(posedge clk);
	endtask

	// phase schedule: register value, operation count
	int phase_q [7] = '{1, 3, 0, 2, 4, 15, 5};
	int phase_n [7] = '{15, 25, 10, 15, 30, 4, 20};

	initial begin
		in_ch.valid = 1'b0;
		in_ch.action = ACT_NONE;
		in_ch.target_qubit = '0;
		in_ch.qubit_mask = '0;
		in_ch.random_value = '0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			amp_re[i] = 0;
			amp_im[i] = 0;
		end
		amp_re[0] = ONE_AMP;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed pass at the reset width of ten qubits
		enqueue_op(make_op(ACT_H, 9, 0, 0));
		enqueue_op(make_op(ACT_INIT, 0, 1023, 0));
		enqueue_op(make_op(ACT_X, 0, 1023, 0));
		enqueue_op(make_op(ACT_X, 0, 0, 0));
		enqueue_op(make_op(ACT_INIT, 0, 0, 0));
		enqueue_op(make_op(ACT_H, 0, 0, 0));
		enqueue_op(make_op(ACT_H, 9, 0, 0));
		enqueue_op(make_op(ACT_Z, 0, 0, 0));
		enqueue_op(make_op(ACT_Z, 9, 0, 0));
		enqueue_op(make_op(ACT_MCX, 3, 1023, 0));
		enqueue_op(make_op(ACT_MCX, 5, 0, 0));      // empty control set
		enqueue_op(make_op(ACT_MCZ, 9, 1023, 0));
		enqueue_op(make_op(ACT_MCZ, 1, 2, 0));      // control is only the target
		enqueue_op(make_op(ACT_Z, 12, 0, 0));       // target out of range
		enqueue_op(make_op(ACT_H, 15, 0, 0));
		enqueue_op(make_op(ACT_MEAS, 10, 0, 0));
		enqueue_op(make_op(ACT_NONE, 3, 1023, 65535));
		enqueue_op(make_op(ACT_MEAS, 9, 0, 65535));
		enqueue_op(make_op(ACT_MEAS, 0, 0, 0));
		drain();

		// random phases, each at its own qubit count
		for (int p = 0; p < 7; p++) begin
			write_qubits(phase_q[p]);
			calm = (p == 2);
			if (p == 0) begin
				enqueue_op(make_op(ACT_INIT, 0, 1023, 0));  // mask above active qubits
				enqueue_op(make_op(ACT_MEAS, 0, 0, 65535));
				enqueue_op(make_op(ACT_MEAS, 1, 0, 0));
			end
			for (int k = 0; k < phase_n[p]; k++)
				enqueue_op(random_op(active_qubits(), phase_q[p] != 15));
			drain();
		end
		calm = 0;

		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
